// ===== sv/sfla_pkg.sv =====
package sfla_pkg;

   typedef struct packed {
      logic        command;
      logic [15:0] request_bytes;
      logic [15:0] block_address;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] granted_address;
      logic [2:0]  outcome;
   } rsp_payload_type;

   localparam logic       CMD_ALLOC   = 1'b0;
   localparam logic       CMD_RELEASE = 1'b1;

   localparam logic [2:0] OUT_GRANTED   = 3'd0;
   localparam logic [2:0] OUT_TOO_LARGE = 3'd1;
   localparam logic [2:0] OUT_NO_MEMORY = 3'd2;
   localparam logic [2:0] OUT_RELEASED  = 3'd3;
   localparam logic [2:0] OUT_LARGE_REL = 3'd4;

   localparam logic [6:0] REFILL_RESET = 7'd20;
   localparam int         CSR_REFILL   = 0;

endpackage

// ===== sv/sfla_ram.sv =====
module sfla_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== sv/segregated_free_list_allocator.sv =====
// channel | direction | handshake          | payload
// req     | in        | req_valid/ready    | command, request_bytes, block_address
// rsp     | out       | rsp_valid/ready    | granted_address, outcome
// csr     | in        | psel/penable/write | refill_count at byte 0
//
// a release or a size rejection passes idle, decode and the response state before the result item;
// a pop adds the link read (pop read, pop wait) between decode and the response state
// a refill computes the product, takes the chunk and writes one link word per further
// carved block; a short pool first runs the restoring division (one quotient bit per cycle)
// an arena grow passes the grow state; a rescue scan inspects the size classes, then reads the link
// reset is synchronous; link memory is not cleared, so no sweep after reset
// req_ready is low from acceptance until the result item is taken
module segregated_free_list_allocator
   import sfla_pkg::*;
#(
   parameter int ALIGN_BYTES     = 8,
   parameter int MAX_SMALL_BYTES = 128,
   parameter int NUM_CLASSES     = 16,
   parameter int ARENA_BYTES     = 65536
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [1:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   localparam int AB       = $clog2(ALIGN_BYTES);
   localparam int CW       = $clog2(NUM_CLASSES);
   localparam int LDEPTH   = 65536 / ALIGN_BYTES;
   localparam int LW       = $clog2(LDEPTH);
   localparam int QB       = 17;
   localparam int QW       = $clog2(QB + 1);
   localparam logic [16:0] ARENA_TOP = 17'(ARENA_BYTES);

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_DECODE  = 13'b0000000000010,
      ST_POP_RD  = 13'b0000000000100,
      ST_POP_WT  = 13'b0000000001000,
      ST_CARVE   = 13'b0000000010000,
      ST_DIV     = 13'b0000000100000,
      ST_TAKE    = 13'b0000001000000,
      ST_LINK    = 13'b0000010000000,
      ST_GROW    = 13'b0000100000000,
      ST_SCAN    = 13'b0001000000000,
      ST_SCAN_RD = 13'b0010000000000,
      ST_SCAN_WT = 13'b0100000000000,
      ST_RESP    = 13'b1000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [15:0]      heads_ff [NUM_CLASSES];
   logic [15:0]      head_wdata;
   logic [CW-1:0]    head_widx;
   logic             head_we;
   logic [6:0]       refill_ff;
   logic [16:0]      pstart_ff, pstart_in, pend_ff, pend_in;
   logic [16:0]      htotal_ff, htotal_in, atop_ff, atop_in;
   logic [CW-1:0]    cls_ff, cls_in, scan_ff, scan_in;
   logic [16:0]      size_ff, size_in;
   logic [6:0]       count_ff, count_in, k_ff, k_in;
   logic [16:0]      total_ff, total_in;
   logic [16:0]      rem_ff, rem_in;
   logic [16:0]      quo_ff, quo_in;
   logic [QW-1:0]    qbit_ff, qbit_in;
   logic [16:0]      grant_ff, grant_in;
   logic [16:0]      ptr_ff, ptr_in;
   rsp_payload_type  rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             lk_we;
   logic [LW-1:0]    lk_waddr, lk_raddr;
   logic [15:0]      lk_wdata, lk_rdata;
   logic [16:0]      mul_a;
   logic [6:0]       mul_b;
   logic [23:0]      mul_p;
   logic [16:0]      left_w, get_w;
   logic [17:0]      trial;
   logic [16:0]      n_eff;
   logic [16:0]      cls_wide;
   logic [16:0]      lcls;
   logic             cfg_wr;

   sfla_ram #(.WIDTH(16), .DEPTH(LDEPTH)) u_links (
      .clock  (clock),
      .wr_en  (lk_we),
      .wr_addr(lk_waddr),
      .wr_data(lk_wdata),
      .rd_addr(lk_raddr),
      .rd_data(lk_rdata)
   );

   // configuration port
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'(4 * CSR_REFILL)) ? {25'd0, refill_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         refill_ff <= REFILL_RESET;
      end else if (cfg_wr && csr_paddr == 2'(4 * CSR_REFILL)) begin
         refill_ff <= csr_pwdata[6:0];
      end
   end

   // multiplier for size * count, narrow operands
   assign mul_p  = 24'(mul_a) * 24'(mul_b);
   assign left_w = (pend_ff >= pstart_ff) ? pend_ff - pstart_ff : 17'd0;
   assign get_w  = 17'(({total_ff, 1'b0}) + ((htotal_ff >> 4) + 17'(ALIGN_BYTES - 1)
                   & ~17'(ALIGN_BYTES - 1)));
   assign trial  = {rem_ff, quo_ff[16]} - {1'b0, size_ff};
   assign n_eff  = (req_payload.request_bytes == 16'd0) ? 17'd1
                   : {1'b0, req_payload.request_bytes};
   assign cls_wide = ((n_eff + 17'(ALIGN_BYTES - 1)) >> AB) - 17'd1;
   assign lcls     = ((left_w + 17'(ALIGN_BYTES - 1)) >> AB) - 17'd1;

   always_comb begin
      state_in     = state_ff;
      pstart_in    = pstart_ff;
      pend_in      = pend_ff;
      htotal_in    = htotal_ff;
      atop_in      = atop_ff;
      cls_in       = cls_ff;
      scan_in      = scan_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      qbit_in      = qbit_ff;
      grant_in     = grant_ff;
      ptr_in       = ptr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      head_we      = 1'b0;
      head_widx    = cls_ff;
      head_wdata   = 16'd0;
      lk_we        = 1'b0;
      lk_waddr     = LW'(ptr_ff >> AB);
      lk_wdata     = 16'd0;
      lk_raddr     = LW'(ptr_ff >> AB);
      mul_a        = size_ff;
      mul_b        = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         // classify, then reject, push, pop or refill
         ST_DECODE: begin
            cls_in  = CW'(cls_wide);
            size_in = 17'((cls_wide + 17'd1) << AB);
            ptr_in  = 17'(req_payload.block_address) & ~17'(ALIGN_BYTES - 1);
            count_in = (refill_ff == 7'd0) ? 7'd1 : refill_ff;
            rsp_in.granted_address = 16'd0;
            state_in = ST_RESP;
            if (cls_wide >= 17'(NUM_CLASSES) || n_eff > 17'(MAX_SMALL_BYTES)) begin
               rsp_in.outcome = (req_payload.command == CMD_RELEASE) ? OUT_LARGE_REL
                                                                     : OUT_TOO_LARGE;
            end else if (req_payload.command == CMD_RELEASE) begin
               rsp_in.outcome = OUT_RELEASED;
               if ((17'(req_payload.block_address) & ~17'(ALIGN_BYTES - 1)) != 17'd0 &&
                   ({1'b0, 17'(req_payload.block_address) & ~17'(ALIGN_BYTES - 1)}
                    + {1'b0, 17'((cls_wide + 17'd1) << AB)}) <= 18'h10000) begin
                  lk_we     = 1'b1;
                  lk_waddr  = LW'(req_payload.block_address >> AB);
                  lk_wdata  = heads_ff[CW'(cls_wide)];
                  head_we   = 1'b1;
                  head_widx = CW'(cls_wide);
                  head_wdata = 16'(req_payload.block_address) & ~16'(ALIGN_BYTES - 1);
               end
            end else if (heads_ff[CW'(cls_wide)] != 16'd0) begin
               ptr_in   = {1'b0, heads_ff[CW'(cls_wide)]};
               state_in = ST_POP_RD;
            end else begin
               state_in = ST_CARVE;
            end
         end
         ST_POP_RD: begin
            state_in = ST_POP_WT;
         end
         ST_POP_WT: begin
            head_we    = 1'b1;
            head_wdata = lk_rdata;
            rsp_in.granted_address = ptr_ff[15:0];
            rsp_in.outcome = OUT_GRANTED;
            state_in = ST_RESP;
         end
         // total = size * count, then take the chunk, divide on a short pool or grow
         ST_CARVE: begin
            total_in = 17'(mul_p);
            state_in = ST_TAKE;
            if (left_w < 17'(mul_p) && left_w >= size_ff) begin
               rem_in   = 17'd0;
               quo_in   = left_w;
               qbit_in  = QW'(QB);
               state_in = ST_DIV;
            end else if (left_w < 17'(mul_p)) begin
               state_in = ST_GROW;
            end
         end
         // restoring division left / size, one bit per cycle
         ST_DIV: begin
            if (!trial[17]) begin
               rem_in = trial[16:0];
               quo_in = {quo_ff[15:0], 1'b1};
            end else begin
               rem_in = {rem_ff[15:0], quo_ff[16]};
               quo_in = {quo_ff[15:0], 1'b0};
            end
            qbit_in = qbit_ff - QW'(1);
            if (qbit_ff == QW'(1)) begin
               count_in = quo_in[6:0];
               state_in = ST_CARVE;
            end
         end
         // take the chunk from the pool
         ST_TAKE: begin
            grant_in  = pstart_ff;
            pstart_in = pstart_ff + total_ff;
            ptr_in    = pstart_ff + size_ff;
            k_in      = 7'd1;
            rsp_in.granted_address = pstart_ff[15:0];
            rsp_in.outcome = OUT_GRANTED;
            if (count_ff > 7'd1) begin
               head_we    = 1'b1;
               head_wdata = 16'(pstart_ff + size_ff);
               state_in   = ST_LINK;
            end else begin
               state_in = ST_RESP;
            end
         end
         // one link word per cycle
         ST_LINK: begin
            lk_we    = 1'b1;
            lk_waddr = LW'(ptr_ff >> AB);
            lk_wdata = (k_ff + 7'd1 < count_ff) ? 16'(ptr_ff + size_ff) : 16'd0;
            ptr_in   = ptr_ff + size_ff;
            k_in     = k_ff + 7'd1;
            if (k_ff + 7'd1 >= count_ff) begin
               state_in = ST_RESP;
            end
         end
         // stash leftover, bump the arena or start the rescue scan
         ST_GROW: begin
            if (left_w != 17'd0 && lcls < 17'(NUM_CLASSES) && pstart_ff != 17'd0 &&
                ({1'b0, pstart_ff} + {1'b0, 17'((lcls + 17'd1) << AB)}) <= 18'h10000) begin
               lk_we      = 1'b1;
               lk_waddr   = LW'(pstart_ff >> AB);
               lk_wdata   = heads_ff[CW'(lcls)];
               head_we    = 1'b1;
               head_widx  = CW'(lcls);
               head_wdata = pstart_ff[15:0];
            end
            if ({1'b0, atop_ff} + {1'b0, get_w} <= {1'b0, ARENA_TOP}) begin
               pstart_in = atop_ff;
               atop_in   = atop_ff + get_w;
               htotal_in = htotal_ff + get_w;
               pend_in   = atop_ff + get_w;
               state_in  = ST_CARVE;
            end else begin
               scan_in  = cls_ff;
               state_in = ST_SCAN;
            end
         end
         // rescue: first non-empty class at or above ours
         ST_SCAN: begin
            if (heads_ff[scan_ff] != 16'd0) begin
               ptr_in   = {1'b0, heads_ff[scan_ff]};
               state_in = ST_SCAN_RD;
            end else if (32'(scan_ff) == NUM_CLASSES - 1) begin
               pstart_in = 17'd0;
               pend_in   = 17'd0;
               rsp_in.granted_address = 16'd0;
               rsp_in.outcome = OUT_NO_MEMORY;
               state_in  = ST_RESP;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_WT;
         end
         ST_SCAN_WT: begin
            head_we    = 1'b1;
            head_widx  = scan_ff;
            head_wdata = lk_rdata;
            pstart_in  = ptr_ff;
            pend_in    = ptr_ff + 17'((17'(scan_ff) + 17'd1) << AB);
            state_in   = ST_CARVE;
         end
         ST_RESP: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
            end else if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready   = (state_ff == ST_DECODE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pstart_ff    <= 17'd0;
         pend_ff      <= 17'd0;
         htotal_ff    <= 17'd0;
         atop_ff      <= 17'(ALIGN_BYTES);
         for (int i = 0; i < NUM_CLASSES; i++) begin
            heads_ff[i] <= 16'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pstart_ff    <= pstart_in;
         pend_ff      <= pend_in;
         htotal_ff    <= htotal_in;
         atop_ff      <= atop_in;
         if (head_we) begin
            heads_ff[head_widx] <= head_wdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cls_ff   <= cls_in;
      scan_ff  <= scan_in;
      size_ff  <= size_in;
      count_ff <= count_in;
      k_ff     <= k_in;
      total_ff <= total_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      qbit_ff  <= qbit_in;
      grant_ff <= grant_in;
      ptr_ff   <= ptr_in;
      rsp_ff   <= rsp_in;
   end

   // a granted address is never null
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.outcome == OUT_GRANTED |-> rsp_payload.granted_address != 16'd0)
      else $error("null grant");

   // no new item while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("accept during result");

   // the arena never grows past its end
   assert property (@(posedge clock) disable iff (reset)
      atop_ff <= ARENA_TOP || $stable(atop_ff))
      else $error("arena overrun");

   // grant register tracks the refill chunk
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LINK |-> rsp_ff.granted_address == grant_ff[15:0])
      else $error("grant mismatch");

endmodule

// ===== tb/sv/segregated_free_list_allocator_tb.sv =====
module segregated_free_list_allocator_tb;
   import sfla_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ALIGN      = 8;
   localparam int unsigned MAX_SMALL  = 128;
   localparam int unsigned CLASSES    = 16;
   localparam int unsigned ARENA      = 65536;
   localparam int unsigned ADDR_SPACE = 65536;
   localparam int          STALL_LIMIT = 20000;
   localparam int          SETTLE      = 300;

   // allocator shadow state and the queue of expected result items
   class alloc_scoreboard;
      bit [6:0]    refill;
      bit [15:0]   heads[CLASSES];
      bit [15:0]   links[int unsigned];
      bit [16:0]   pool_lo, pool_hi, heap_taken, arena_next;
      rsp_payload_type pending[$];
      int unsigned live_addr[$];
      int unsigned live_size[$];
      int          errors;

      function new();
         refill = REFILL_RESET;
         foreach (heads[i]) heads[i] = '0;
         pool_lo = '0;
         pool_hi = '0;
         heap_taken = '0;
         arena_next = ALIGN;
         errors = 0;
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function int unsigned size_class(int unsigned n);
         if (n == 0) n = 1;
         return (n + ALIGN - 1) / ALIGN - 1;
      endfunction

      function int unsigned link_of(int unsigned a);
         if (links.exists(a / ALIGN)) return links[a / ALIGN];
         return 0;
      endfunction

      function void push_free(int unsigned c, int unsigned a);
         if (c >= CLASSES || a == 0) return;
         if (a + (c + 1) * ALIGN > ADDR_SPACE) return;
         links[a / ALIGN] = heads[c];
         heads[c] = 16'(a);
      endfunction

      // carve up to count blocks from the pool, refilling from arena or rescue
      function int unsigned carve(int unsigned size, ref int unsigned count);
         int unsigned left, total, grab, res;
         bit found;
         while (1) begin
            left = (pool_hi >= pool_lo) ? pool_hi - pool_lo : 0;
            total = size * count;
            if (left >= total || left >= size) begin
               if (left < total) begin
                  count = left / size;
                  total = size * count;
               end
               res = pool_lo;
               pool_lo = 17'(pool_lo + total);
               return res;
            end
            grab = 2 * total + ((heap_taken >> 4) + ALIGN - 1) / ALIGN * ALIGN;
            if (left > 0) push_free(size_class(left), pool_lo);
            if (arena_next + grab <= ARENA) begin
               pool_lo = arena_next;
               arena_next = 17'(arena_next + grab);
               heap_taken = 17'(heap_taken + grab);
               pool_hi = 17'(pool_lo + grab);
               continue;
            end
            found = 0;
            for (int unsigned c = size_class(size); c < CLASSES; c++) begin
               if (heads[c] != 0) begin
                  pool_lo = heads[c];
                  heads[c] = 16'(link_of(heads[c]));
                  pool_hi = 17'(pool_lo + (c + 1) * ALIGN);
                  found = 1;
                  break;
               end
            end
            if (!found) begin
               pool_lo = '0;
               pool_hi = '0;
               return 0;
            end
         end
      endfunction

      // accepted input item: predict its result item
      function void note(req_payload_type r);
         int unsigned n, c, size, count, chunk;
         rsp_payload_type e;
         n = r.request_bytes;
         c = size_class(n);
         e.granted_address = '0;
         if (r.command == CMD_RELEASE) begin
            if (c >= CLASSES || n > MAX_SMALL) e.outcome = OUT_LARGE_REL;
            else begin
               push_free(c, r.block_address - r.block_address % ALIGN);
               e.outcome = OUT_RELEASED;
            end
         end else if (c >= CLASSES || n > MAX_SMALL) begin
            e.outcome = OUT_TOO_LARGE;
         end else if (heads[c] != 0) begin
            e.granted_address = heads[c];
            heads[c] = 16'(link_of(heads[c]));
            e.outcome = OUT_GRANTED;
         end else begin
            size = (c + 1) * ALIGN;
            count = (refill == 0) ? 1 : refill;
            chunk = carve(size, count);
            if (chunk == 0) e.outcome = OUT_NO_MEMORY;
            else begin
               if (count > 1) begin
                  heads[c] = 16'(chunk + size);
                  for (int unsigned k = 1; k + 1 < count; k++)
                     links[(chunk + k * size) / ALIGN] = 16'(chunk + (k + 1) * size);
                  links[(chunk + (count - 1) * size) / ALIGN] = 0;
               end
               e.granted_address = 16'(chunk);
               e.outcome = OUT_GRANTED;
            end
         end
         if (e.outcome == OUT_GRANTED) begin
            live_addr.push_back(e.granted_address);
            live_size.push_back(n);
         end
         pending.push_back(e);
      endfunction

      task check(rsp_payload_type got);
         rsp_payload_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result item %h", got));
         end else begin
            e = pending.pop_front();
            if (got.outcome !== e.outcome)
               report($sformatf("outcome %0d, want %0d", got.outcome, e.outcome));
            if (got.granted_address !== e.granted_address)
               report($sformatf("address %h, want %h",
                                got.granted_address, e.granted_address));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   alloc_scoreboard sb = new();
   bit send_steady = 0;
   bit take_steady = 0;
   int idle_cycles = 0;

   segregated_free_list_allocator DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stall before each item, checked at the edge
   initial begin
      int d;
      @(negedge clock);
      forever begin
         d = take_steady ? 0 : $urandom_range(0, 11);
         if (d > 0) begin
            rsp_ready <= 1'b0;
            repeat (d) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check(rsp_payload);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task send_item(logic cmd, logic [15:0] nbytes, logic [15:0] addr);
      int d;
      d = send_steady ? 0 : $urandom_range(0, 11);
      if (d > 0) begin
         req_valid <= 1'b0;
         repeat (d) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{command: cmd, request_bytes: nbytes, block_address: addr};
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note(req_payload);
      @(negedge clock);
   endtask

   // hold the sender until every result item is back, then let the block settle
   task drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task write_refill(logic [6:0] v);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 2'(CSR_REFILL * 4);
      csr_pwdata <= {25'd0, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.refill = v;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task random_item();
      int unsigned pick, k;
      pick = $urandom_range(0, 99);
      if (pick < 20 && sb.live_addr.size() > 0) begin
         k = $urandom_range(0, sb.live_addr.size() - 1);
         send_item(CMD_RELEASE, 16'(sb.live_size[k]), 16'(sb.live_addr[k]));
         sb.live_addr.delete(k);
         sb.live_size.delete(k);
      end else if (pick < 88) begin
         send_item(CMD_ALLOC, 16'($urandom_range(0, MAX_SMALL)), 16'($urandom()));
      end else begin
         send_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      logic [6:0] settings[5] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd37};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: size extremes, both commands, odd releases, reset refill count
      send_item(CMD_ALLOC, 16'd1, 16'h0);
      send_item(CMD_ALLOC, 16'd0, 16'hFFFF);
      send_item(CMD_ALLOC, 16'd8, 16'h0);
      send_item(CMD_ALLOC, 16'd9, 16'h0);
      send_item(CMD_ALLOC, 16'd128, 16'h0);
      send_item(CMD_ALLOC, 16'd129, 16'h0);
      send_item(CMD_ALLOC, 16'hFFFF, 16'h0);
      send_item(CMD_RELEASE, 16'd129, 16'h0100);
      send_item(CMD_RELEASE, 16'hFFFF, 16'hFFFF);
      send_item(CMD_RELEASE, 16'd8, 16'h0000);
      send_item(CMD_RELEASE, 16'd8, 16'h0007);
      send_item(CMD_RELEASE, 16'd16, 16'hFFF8);
      send_item(CMD_RELEASE, 16'd8, 16'hFFF8);
      send_item(CMD_RELEASE, 16'd0, 16'h2345);
      send_item(CMD_ALLOC, 16'd1, 16'h0);
      send_item(CMD_ALLOC, 16'd8, 16'h0);
      send_item(CMD_RELEASE, 16'd128, 16'hAAAB);
      send_item(CMD_ALLOC, 16'd121, 16'h0);
      send_item(CMD_ALLOC, 16'd128, 16'h0);
      send_item(CMD_ALLOC, 16'd64, 16'h5555);

      // random phases over several refill counts
      foreach (settings[p]) begin
         drain();
         write_refill(settings[p]);
         send_steady = (p % 2) == 1;
         take_steady = p == 3;
         for (int i = 0; i < 80; i++) begin
            if (i == 40) begin
               send_steady = !send_steady;
               take_steady = 0;
            end
            random_item();
         end
      end

      drain();
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
